>>> src/sam_pkg.sv
package sam_pkg;

	localparam int ENTRIES = 64;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_32 = 2'd2;
	localparam logic [1:0] SIZE_64 = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [31:0] address;
		logic [1:0]  size_code;
		logic [63:0] write_value;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        status;
	} rsp_t;

	// Access broadcast to every cell while an item is in flight
	typedef struct packed {
		logic        opcode;
		logic [31:0] address;
		logic [63:0] mask;
		logic [63:0] wdata;
	} cmd_t;

	// Token that walks the row of cells, one cell per cycle
	typedef struct packed {
		logic             active;
		logic             done;
		logic             append;
		logic [CNT_W-1:0] left;
		logic [63:0]      rdata;
	} token_t;

	function automatic logic [63:0] width_mask(input logic [1:0] code);
		logic [63:0] m;
		unique case (code)
			SIZE_8:  m = 64'h0000_0000_0000_00FF;
			SIZE_16: m = 64'h0000_0000_0000_FFFF;
			SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
			SIZE_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

>>> src/sam_cell.sv
module sam_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sam_pkg::cmd_t   cmd,
	input  sam_pkg::token_t tk_in,
	output sam_pkg::token_t tk_q
);
	import sam_pkg::*;

	logic [31:0] tag_q;
	logic [63:0] data_q;
	logic        live;
	logic        hit;
	logic        app;
	token_t      tk_nxt;

	// Decide whether this cell serves the token
	always_comb begin
		live   = tk_in.active && !tk_in.done;
		hit    = live && (tk_in.left != '0) && (tag_q == cmd.address);
		app    = live && (tk_in.left == '0);
		tk_nxt = tk_in;
		if (tk_in.left != '0) begin
			tk_nxt.left = tk_in.left - CNT_W'(1);
		end
		if (hit) begin
			tk_nxt.done  = 1'b1;
			tk_nxt.rdata = (cmd.opcode == OP_READ) ? (data_q & cmd.mask) : 64'd0;
		end else if (app) begin
			tk_nxt.done   = 1'b1;
			tk_nxt.append = 1'b1;
			tk_nxt.rdata  = 64'd0;
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk_q <= '0;
		end else begin
			tk_q <= tk_nxt;
		end
	end

	// Update the stored entry on a write hit or an append
	always_ff @(posedge clk) begin
		if (app) begin
			tag_q  <= cmd.address;
			data_q <= (cmd.opcode == OP_WRITE) ? cmd.wdata : 64'd0;
		end else if (hit && cmd.opcode == OP_WRITE) begin
			data_q <= cmd.wdata;
		end
	end

endmodule

>>> src/sparse_associative_memory.sv
// Sparse associative memory: a table of up to ENTRIES address tags, each with
// a 64-bit cell, kept in a row of cells.
// Input: an access (opcode, address, size_code, write_value) transfers at a
// rising edge where start is high and busy is low. busy stays high until the
// result is out; one access is worked on at a time.
// The access is broadcast to all cells while a token walks the row, one cell
// per cycle. The first cell holding a matching tag serves it; the first free
// cell appends a new entry (value zero, or the masked write value).
// Output: done is high for exactly one cycle with rsp valid; the receiver
// cannot stall, so the result must be taken in that cycle. read_data is the
// masked cell on a read and zero on a write; status is 1 when the address
// missed and the table was full, in which case nothing is stored.
// Path: the access is registered in cmd_q and head_q at the accepting edge;
// the token then walks the register of every cell of the row, and done and
// rsp are registered from the end of the row. A new access may be started
// in the cycle done is high.
// Reset: clears the entry count and all control state; the cell contents are
// not cleared and are never read before they are written.
module sparse_associative_memory (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sam_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output sam_pkg::rsp_t rsp
);
	import sam_pkg::*;

	logic             busy_q;
	logic             done_q;
	rsp_t             rsp_q;
	cmd_t             cmd_q;
	token_t           head_q;
	token_t           head_d;
	logic [CNT_W-1:0] count_q;
	token_t           tk [0:ENTRIES];
	token_t           tail;
	logic             accept;

	assign accept = start && !busy_q;
	assign tk[0]  = head_q;
	assign tail   = tk[ENTRIES];

	// Row of cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		sam_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd_q),
			.tk_in (tk[i]),
			.tk_q  (tk[i+1])
		);
	end

	// Capture the access on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.opcode  <= req.opcode;
			cmd_q.address <= req.address;
			cmd_q.mask    <= width_mask(req.size_code);
			cmd_q.wdata   <= req.write_value & width_mask(req.size_code);
		end
	end

	// Build the token that enters the row
	always_comb begin
		head_d = '0;
		if (accept) begin
			head_d.active = 1'b1;
			head_d.left   = count_q;
		end
	end

	// Launch the token, collect it at the end of the row, track the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			done_q <= tail.active;
			head_q <= head_d;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.active) begin
				busy_q <= 1'b0;
			end
			if (tail.active && tail.append) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Hold the result for its strobe cycle
	always_ff @(posedge clk) begin
		if (tail.active) begin
			rsp_q.read_data <= tail.done ? tail.rdata : 64'd0;
			rsp_q.status    <= tail.done ? STATUS_OK : STATUS_FULL;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// A result only follows an access in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result without access in flight");

	// The count never exceeds the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count overflow");

	// Full status only when the table is full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == STATUS_FULL) |-> (count_q == CNT_W'(ENTRIES)))
		else $error("full status with free entries");

	// The count grows by at most one per access
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count jumped");

	// A transfer launches the token next cycle
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (head_q.active && busy_q))
		else $error("token not launched");

endmodule
